// ===== rtl/button_report_change_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the change detector.
// ----------------------------------------------------------------------------
`ifndef BUTTON_REPORT_CHANGE_DETECTOR_DEFINES_SVH
`define BUTTON_REPORT_CHANGE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCD_ASSERT_IMPL(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCD_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Change detector package
// Widths, codes and the types passed between the front, queue and back.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int MAX_BITS         = 48;
	localparam int IDX_W            = 6;
	localparam int ENC_W            = 8;
	localparam int BUTTON_BYTES_DEF = 6;
	localparam int UNMAPPED_LO      = 8;
	localparam int UNMAPPED_HI      = 10;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [ENC_W-1:0] ENC_TOP    = 8'h0f;
	localparam logic [ENC_W-1:0] ENC_BOTTOM = 8'h00;

	localparam logic EV_BUTTON  = 1'b0;
	localparam logic EV_ENCODER = 1'b1;

	typedef struct packed {
		logic [MAX_BITS-1:0] mask;
		logic [MAX_BITS-1:0] lvl;
		logic                shift;
		logic                enc_evt;
		logic                enc_up;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/bcd_if.sv =====
// ----------------------------------------------------------------------------
// Change detector channels
// Valid/ready interfaces for reports in and events out.
// ----------------------------------------------------------------------------
interface bcd_in_if;
	logic                             valid;
	logic                             ready;
	logic [bcd_pkg::MAX_BITS-1:0]     button_bits;
	logic [bcd_pkg::ENC_W-1:0]        encoder_position;

	modport source (output valid, output button_bits, output encoder_position, input ready);
	modport sink (input valid, input button_bits, input encoder_position, output ready);
endinterface

interface bcd_out_if;
	logic                         valid;
	logic                         ready;
	logic                         event_kind;
	logic [bcd_pkg::IDX_W-1:0]    button_index;
	logic                         pressed_now;
	logic                         shift_held;
	logic                         turned_up;
	logic                         last_event;

	modport source (output valid, output event_kind, output button_index, output pressed_now,
		output shift_held, output turned_up, output last_event, input ready);
	modport sink (input valid, input event_kind, input button_index, input pressed_now,
		input shift_held, input turned_up, input last_event, output ready);
endinterface

// ===== rtl/bcd_front.sv =====
// ----------------------------------------------------------------------------
// Change detector front
// Accepts reports, compares them with the known levels and queues a job.
// ----------------------------------------------------------------------------
module bcd_front #(
	parameter int BUTTON_BYTES = bcd_pkg::BUTTON_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bcd_in_if.sink             report,
	input  bcd_pkg::q_status_t q_status,
	output logic               push,
	output bcd_pkg::job_t      job
);

	localparam int SCAN_BITS = (BUTTON_BYTES * 8 > bcd_pkg::MAX_BITS) ?
		bcd_pkg::MAX_BITS : BUTTON_BYTES * 8;

	logic [SCAN_BITS-1:0]          known_q;
	logic [SCAN_BITS-1:0]          new_lvl;
	logic [SCAN_BITS-1:0]          emit_mask;
	logic [SCAN_BITS-1:0]          keep_mask;
	logic [bcd_pkg::ENC_W-1:0]     enc_q;
	logic [bcd_pkg::ENC_W-1:0]     enc_new;
	logic                          accept;
	logic                          enc_chg;

	always_comb begin
		for (int n = 0; n < SCAN_BITS; n++) begin
			emit_mask[n] = (n != 0) && ((n < bcd_pkg::UNMAPPED_LO) || (n > bcd_pkg::UNMAPPED_HI));
			keep_mask[n] = (n != 0);
		end
	end

	assign report.ready = !q_status.full;
	assign accept       = report.valid && report.ready;
	assign new_lvl      = report.button_bits[SCAN_BITS-1:0];
	assign enc_new      = report.encoder_position;
	assign enc_chg      = enc_new != enc_q;

	always_comb begin
		job.mask    = bcd_pkg::MAX_BITS'((new_lvl ^ known_q) & emit_mask);
		job.lvl     = bcd_pkg::MAX_BITS'(new_lvl);
		job.shift   = report.button_bits[0];
		job.enc_evt = enc_chg;
		job.enc_up  = ((enc_q < enc_new) ||
			(enc_q == bcd_pkg::ENC_TOP && enc_new == bcd_pkg::ENC_BOTTOM)) &&
			!(enc_q == bcd_pkg::ENC_BOTTOM && enc_new == bcd_pkg::ENC_TOP);
	end

	assign push = accept && ((|job.mask) || enc_chg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= '0;
			enc_q   <= '0;
		end else if (accept) begin
			known_q <= new_lvl & keep_mask;
			enc_q   <= enc_new;
		end
	end

endmodule

// ===== rtl/bcd_fifo.sv =====
// ----------------------------------------------------------------------------
// Change detector job queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module bcd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bcd_pkg::job_t      wr_job,
	input  logic               pop,
	output bcd_pkg::job_t      rd_job,
	output bcd_pkg::q_status_t q_status
);

	localparam int PTR_W = $clog2(bcd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(bcd_pkg::QUEUE_DEPTH + 1);

	bcd_pkg::job_t    slot_q [bcd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_job         = slot_q[rd_ptr_q];
	assign q_status.full  = count_q == CNT_W'(bcd_pkg::QUEUE_DEPTH);
	assign q_status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(bcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(bcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bcd_back.sv =====
// ----------------------------------------------------------------------------
// Change detector back
// Walks a queued job bit by bit and emits its events through an output register.
// ----------------------------------------------------------------------------
module bcd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bcd_pkg::job_t      rd_job,
	input  bcd_pkg::q_status_t q_status,
	output logic               pop,
	bcd_out_if.source          events
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                       state_q;
	logic [bcd_pkg::MAX_BITS-1:0] mask_q;
	logic [bcd_pkg::MAX_BITS-1:0] lvl_q;
	logic [bcd_pkg::IDX_W-1:0]    idx_q;
	logic                         shift_q;
	logic                         enc_evt_q;
	logic                         enc_up_q;
	logic                         out_valid_q;
	logic                         kind_q;
	logic [bcd_pkg::IDX_W-1:0]    index_q;
	logic                         pressed_q;
	logic                         shift_out_q;
	logic                         up_q;
	logic                         last_q;
	logic                         advance;
	logic                         scanning;
	logic                         done;
	logic                         emit;
	logic                         emit_btn;

	assign advance  = !out_valid_q || events.ready;
	assign scanning = (state_q == ST_SCAN) && advance;
	assign done     = mask_q == '0;
	assign emit_btn = scanning && !done && mask_q[0];
	assign emit     = emit_btn || (scanning && done && enc_evt_q);
	assign pop      = (state_q == ST_IDLE) && !q_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emit;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scanning && done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mask_q    <= rd_job.mask;
			lvl_q     <= rd_job.lvl;
			idx_q     <= '0;
			shift_q   <= rd_job.shift;
			enc_evt_q <= rd_job.enc_evt;
			enc_up_q  <= rd_job.enc_up;
		end else if (scanning && !done) begin
			mask_q <= mask_q >> 1;
			lvl_q  <= lvl_q >> 1;
			idx_q  <= idx_q + 1'b1;
		end
		if (emit) begin
			shift_out_q <= shift_q;
			if (emit_btn) begin
				kind_q    <= bcd_pkg::EV_BUTTON;
				index_q   <= idx_q;
				pressed_q <= lvl_q[0];
				up_q      <= 1'b0;
				last_q    <= (mask_q[bcd_pkg::MAX_BITS-1:1] == '0) && !enc_evt_q;
			end else begin
				kind_q    <= bcd_pkg::EV_ENCODER;
				index_q   <= '0;
				pressed_q <= 1'b0;
				up_q      <= enc_up_q;
				last_q    <= 1'b1;
			end
		end
	end

	assign events.valid        = out_valid_q;
	assign events.event_kind   = kind_q;
	assign events.button_index = index_q;
	assign events.pressed_now  = pressed_q;
	assign events.shift_held   = shift_out_q;
	assign events.turned_up    = up_q;
	assign events.last_event   = last_q;

endmodule

// ===== rtl/button_report_change_detector.sv =====
// ----------------------------------------------------------------------------
// Button report change detector
// Turns controller reports into button change and encoder move transactions.
// ----------------------------------------------------------------------------
// The report channel takes one transaction per controller report: the button
// bitmap and the encoder position byte. The event channel gives one
// transaction per changed mapped button, in ascending bit order, then one
// for an encoder move; last_event marks the final one of each report.
// A report that changes nothing gives no transaction at all.
// The front compares each report with the known levels in its accept cycle
// and places a job in a two-entry queue, so reports are taken while the
// back is still emitting. The back walks one bit of the job per cycle
// while its output register is not stalled. When the receiver stalls,
// the output register holds its transaction, the walk pauses, and once
// the queue is full the report channel drops ready. Reset clears the
// known levels to all released, the known encoder value to zero, and
// empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`include "button_report_change_detector_defines.svh"

module button_report_change_detector #(
	parameter int BUTTON_BYTES = bcd_pkg::BUTTON_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bcd_in_if.sink    report,
	bcd_out_if.source events
);

	bcd_pkg::job_t      wr_job;
	bcd_pkg::job_t      rd_job;
	bcd_pkg::q_status_t q_status;
	logic               push;
	logic               pop;
	logic               btn_event;
	logic               idx_mapped;

	bcd_front #(
		.BUTTON_BYTES(BUTTON_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.report  (report),
		.q_status(q_status),
		.push    (push),
		.job     (wr_job)
	);

	bcd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_job  (wr_job),
		.pop     (pop),
		.rd_job  (rd_job),
		.q_status(q_status)
	);

	bcd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_job  (rd_job),
		.q_status(q_status),
		.pop     (pop),
		.events  (events)
	);

	assign btn_event  = events.valid && (events.event_kind == bcd_pkg::EV_BUTTON);
	assign idx_mapped = (events.button_index != '0) &&
		((events.button_index < bcd_pkg::IDX_W'(bcd_pkg::UNMAPPED_LO)) ||
		(events.button_index > bcd_pkg::IDX_W'(bcd_pkg::UNMAPPED_HI)));

	`BCD_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !q_status.full, "push into full queue")
	`BCD_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, !q_status.empty, "pop from empty queue")
	`BCD_ASSERT_IMPL(a_mapped_index, clk, arst_n, btn_event, idx_mapped, "event on unmapped bit")

endmodule

// ===== sim/button_report_change_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button report change detector testbench
// Offers controller reports on the report channel and checks every event
// transaction against a predictor that tracks the known button levels and
// encoder value. A directed set covers full-bitmap flips, the shift bit,
// the unmapped bits, high encoder values and the wrap between 15 and 0.
// Random reports then follow, mostly small changes to the last report.
// Both channels idle at random, the receiver holds off once for a long
// stretch, and the sender pauses more than once until all events are in.
// ----------------------------------------------------------------------------
module button_report_change_detector_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 28;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 90;
	localparam int SETTLE       = 64;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		logic                      kind;
		logic [bcd_pkg::IDX_W-1:0] index;
		logic                      pressed;
		logic                      shift;
		logic                      up;
		logic                      is_last;
	} event_rec_t;

	class change_tracker;
		logic [bcd_pkg::MAX_BITS-1:0] known_levels;
		logic [bcd_pkg::ENC_W-1:0]    known_position;
		event_rec_t                   events_due[$];
		int                           reports_taken;
		int                           buttons_seen;
		int                           moves_seen;
		int                           errors;

		function new();
			known_levels   = '0;
			known_position = '0;
			reports_taken  = 0;
			buttons_seen   = 0;
			moves_seen     = 0;
			errors         = 0;
		endfunction

		function void note_error(string what);
			errors++;
			if (errors <= SHOWN_ERRORS)
				$display("[%0t] %s", $time, what);
		endfunction

		function void take_report(logic [bcd_pkg::MAX_BITS-1:0] bits,
			logic [bcd_pkg::ENC_W-1:0] pos);
			event_rec_t due[$];
			event_rec_t rec;
			int         scan;
			logic       up;
			scan = bcd_pkg::BUTTON_BYTES_DEF * 8;
			if (scan > bcd_pkg::MAX_BITS)
				scan = bcd_pkg::MAX_BITS;
			reports_taken++;
			for (int n = 1; n < scan; n++) begin
				if (bits[n] !== known_levels[n]) begin
					known_levels[n] = bits[n];
					if (n < bcd_pkg::UNMAPPED_LO || n > bcd_pkg::UNMAPPED_HI) begin
						rec         = '0;
						rec.kind    = bcd_pkg::EV_BUTTON;
						rec.index   = bcd_pkg::IDX_W'(n);
						rec.pressed = bits[n];
						rec.shift   = bits[0];
						due.push_back(rec);
					end
				end
			end
			if (pos !== known_position) begin
				up = ((known_position < pos) ||
					(known_position == bcd_pkg::ENC_TOP && pos == bcd_pkg::ENC_BOTTOM)) &&
					!(known_position == bcd_pkg::ENC_BOTTOM && pos == bcd_pkg::ENC_TOP);
				rec       = '0;
				rec.kind  = bcd_pkg::EV_ENCODER;
				rec.shift = bits[0];
				rec.up    = up;
				due.push_back(rec);
				known_position = pos;
			end
			if (due.size() > 0)
				due[due.size()-1].is_last = 1'b1;
			foreach (due[k])
				events_due.push_back(due[k]);
		endfunction

		function void check_event(event_rec_t got);
			event_rec_t exp;
			if (events_due.size() == 0) begin
				note_error($sformatf({"unexpected event kind=%0d idx=%0d pressed=%0d",
					" shift=%0d up=%0d last=%0d"},
					got.kind, got.index, got.pressed, got.shift, got.up, got.is_last));
				return;
			end
			exp = events_due.pop_front();
			if (exp.kind == bcd_pkg::EV_BUTTON)
				buttons_seen++;
			else
				moves_seen++;
			if (got.kind !== exp.kind || got.index !== exp.index ||
				got.pressed !== exp.pressed || got.shift !== exp.shift ||
				got.up !== exp.up || got.is_last !== exp.is_last) begin
				note_error($sformatf({"mismatch: expected kind=%0d idx=%0d pressed=%0d",
					" shift=%0d up=%0d last=%0d,",
					" got kind=%0d idx=%0d pressed=%0d shift=%0d up=%0d last=%0d"},
					exp.kind, exp.index, exp.pressed, exp.shift, exp.up, exp.is_last,
					got.kind, got.index, got.pressed, got.shift, got.up, got.is_last));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bcd_in_if  report_ch();
	bcd_out_if events_ch();

	button_report_change_detector i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.report(report_ch),
		.events(events_ch)
	);

	change_tracker                tracker;
	bit                           calm = 1'b0;
	bit                           hold_request = 1'b0;
	int                           cycle_count = 0;
	logic [bcd_pkg::MAX_BITS-1:0] sent_bits = '0;
	logic [bcd_pkg::ENC_W-1:0]    sent_pos = '0;

	initial clk = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("button_report_change_detector_tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin : watch
		event_rec_t got;
		if (arst_n && report_ch.valid && report_ch.ready)
			tracker.take_report(report_ch.button_bits, report_ch.encoder_position);
		if (arst_n && events_ch.valid && events_ch.ready) begin
			got.kind    = events_ch.event_kind;
			got.index   = events_ch.button_index;
			got.pressed = events_ch.pressed_now;
			got.shift   = events_ch.shift_held;
			got.up      = events_ch.turned_up;
			got.is_last = events_ch.last_event;
			tracker.check_event(got);
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		events_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				events_ch.ready <= 1'b0;
			end else if (calm) begin
				events_ch.ready <= 1'b1;
			end else begin
				events_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_report(logic [bcd_pkg::MAX_BITS-1:0] bits,
		logic [bcd_pkg::ENC_W-1:0] pos);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			report_ch.valid <= 1'b0;
			@(negedge clk);
		end
		report_ch.valid            <= 1'b1;
		report_ch.button_bits      <= bits;
		report_ch.encoder_position <= pos;
		sent_bits = bits;
		sent_pos  = pos;
		do
			@(posedge clk);
		while (!report_ch.ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		report_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.events_due.size() != 0);
	endtask

	task automatic pick_report(output logic [bcd_pkg::MAX_BITS-1:0] bits,
		output logic [bcd_pkg::ENC_W-1:0] pos);
		logic [63:0] wide;
		int          mode;
		int          flips;
		mode = $urandom_range(0, 99);
		bits = sent_bits;
		pos  = sent_pos;
		if (mode < 60) begin
			flips = $urandom_range(1, 4);
			repeat (flips)
				bits[$urandom_range(0, bcd_pkg::MAX_BITS-1)] ^= 1'b1;
			if (sent_pos > bcd_pkg::ENC_TOP)
				pos = bcd_pkg::ENC_W'($urandom_range(0, bcd_pkg::ENC_TOP));
			else case ($urandom_range(0, 3))
				1: pos = (sent_pos + 8'd1) & bcd_pkg::ENC_TOP;
				2: pos = (sent_pos - 8'd1) & bcd_pkg::ENC_TOP;
				default: pos = sent_pos;
			endcase
		end else if (mode < 80) begin
			wide = {$urandom(), $urandom()};
			bits = wide[bcd_pkg::MAX_BITS-1:0];
			pos  = bcd_pkg::ENC_W'($urandom_range(0, 255));
		end else if (mode < 90) begin
			bits[0] = 1'($urandom_range(0, 1));
		end else begin
			bits[$urandom_range(bcd_pkg::UNMAPPED_LO, bcd_pkg::UNMAPPED_HI)] ^= 1'b1;
		end
	endtask

	initial begin
		logic [bcd_pkg::MAX_BITS-1:0] bits;
		logic [bcd_pkg::ENC_W-1:0]    pos;
		tracker = new();
		report_ch.valid            = 1'b0;
		report_ch.button_bits      = '0;
		report_ch.encoder_position = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_report(48'h0000_0000_0000, 8'h00);
		send_report(48'h0000_0000_0001, 8'h00);
		send_report(48'hFFFF_FFFF_FFFF, 8'hFF);
		send_report(48'h0000_0000_0000, 8'h00);
		send_report(48'h0000_0000_0700, 8'h00);
		send_report(48'h0000_0000_0701, 8'h00);
		send_report(48'h0000_0000_0000, 8'h00);
		send_report(48'h0000_0000_0000, 8'h0F);
		send_report(48'h0000_0000_0000, 8'h00);
		send_report(48'h0000_0000_0000, 8'h0F);
		send_report(48'h0000_0000_0000, 8'h0E);
		send_report(48'h0000_0000_0000, 8'h0F);
		send_report(48'h8000_0000_0001, 8'h0F);
		send_report(48'h0000_0000_0002, 8'h0F);
		send_report(48'hAAAA_AAAA_AAAA, 8'h10);
		send_report(48'h5555_5555_5555, 8'hC8);
		send_report(48'h5555_5555_5555, 8'hC9);
		send_report(48'h5555_5555_5555, 8'h00);
		send_report(48'h0000_0000_0780, 8'h00);
		send_report(48'h0000_0000_0800, 8'h01);
		send_report(48'hFFFF_FFFF_FFFE, 8'h0F);
		wait_drained();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 20)
				hold_request = 1'b1;
			calm = (k >= 60 && k < 85);
			pick_report(bits, pos);
			send_report(bits, pos);
			if (k == 45 || k == 75)
				wait_drained();
		end
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		if (tracker.events_due.size() != 0)
			tracker.note_error($sformatf("%0d events never arrived", tracker.events_due.size()));
		$display("Covered %0d reports: %0d button and %0d encoder transactions checked,",
			tracker.reports_taken, tracker.buttons_seen, tracker.moves_seen);
		$display("with random idling, a %0d-cycle receiver hold-off and drained pauses; %0d errors.",
			HOLD_CYCLES, tracker.errors);
		if (tracker.errors == 0)
			$display("button_report_change_detector_tb: clean");
		else
			$display("button_report_change_detector_tb: errors");
		$finish;
	end

endmodule
